FILE: design/nnk_pkg.sv
// Shared types and constants for the nearest-neighbour top-k selector.
// No dependencies; every other file of the block uses this package.
package nnk_pkg;

   localparam int MAX_KEEP_DEFAULT = 16;
   localparam int KEEP_COUNT_W     = 5;
   localparam int INDEX_W          = 16;
   localparam int DIST_W           = 32;

   localparam logic [KEEP_COUNT_W-1:0] KEEP_RESET = KEEP_COUNT_W'(12);

   // Operation applied to every cell of the chain at once
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REPLACE,
      OP_SHIFT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DIST_W-1:0]   distance;
      logic [INDEX_W-1:0]  target;
   } cmd_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic                occ;
      logic                greater;
      logic [DIST_W-1:0]   distance;
      logic [INDEX_W-1:0]  target;
   } cell_type;

endpackage

FILE: design/nnk_ifs.sv
// Valid/ready channel interfaces for candidate and edge words.
// Depends on nnk_pkg for field widths.
interface nnk_req_if;
   logic                         valid;
   logic                         ready;
   logic [nnk_pkg::INDEX_W-1:0]  source_index;
   logic [nnk_pkg::INDEX_W-1:0]  neighbour_index;
   logic [nnk_pkg::DIST_W-1:0]   distance;
   logic                         group_end;

   modport source (output valid, source_index, neighbour_index, distance, group_end,
                   input ready);
   modport sink   (input valid, source_index, neighbour_index, distance, group_end,
                   output ready);
endinterface

interface nnk_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nnk_pkg::INDEX_W-1:0]  edge_source;
   logic [nnk_pkg::INDEX_W-1:0]  edge_target;
   logic [nnk_pkg::DIST_W-1:0]   edge_distance;
   logic                         edge_last;

   modport source (output valid, edge_source, edge_target, edge_distance, edge_last,
                   input ready);
   modport sink   (input valid, edge_source, edge_target, edge_distance, edge_last,
                   output ready);
endinterface

FILE: design/nnk_cell.sv
// One slot of the sorted insertion chain: holds one kept edge.
// Depends on nnk_pkg; instantiated by nnk_chain.
module nnk_cell (
   input  logic              clock,
   input  logic              reset,
   input  nnk_pkg::cmd_type  cmd,
   input  nnk_pkg::cell_type left,
   input  nnk_pkg::cell_type right,
   output nnk_pkg::cell_type own
);
   import nnk_pkg::*;

   logic                occ_ff, occ_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [INDEX_W-1:0]  target_ff, target_in;
   logic                greater;

   assign greater = occ_ff && (dist_ff > cmd.distance);

   always_comb begin
      occ_in    = occ_ff;
      dist_in   = dist_ff;
      target_in = target_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            // keep above the insertion point, take the new edge at it, shift below it
            if (!greater) begin
               if (left.greater) begin
                  occ_in    = 1'b1;
                  dist_in   = cmd.distance;
                  target_in = cmd.target;
               end else begin
                  occ_in    = left.occ;
                  dist_in   = left.distance;
                  target_in = left.target;
               end
            end
         end
         OP_REPLACE: begin
            // head is dropped: move up above the insertion point
            if (right.greater) begin
               dist_in   = right.distance;
               target_in = right.target;
            end else if (greater) begin
               dist_in   = cmd.distance;
               target_in = cmd.target;
            end
         end
         OP_SHIFT: begin
            occ_in    = right.occ;
            dist_in   = right.distance;
            target_in = right.target;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff   <= dist_in;
      target_ff <= target_in;
   end

   assign own.occ      = occ_ff;
   assign own.greater  = greater;
   assign own.distance = dist_ff;
   assign own.target   = target_ff;

endmodule

FILE: design/nnk_chain.sv
// Row of nnk_cell slots kept in emission order, largest distance at the head.
// Depends on nnk_pkg and nnk_cell.
module nnk_chain #(
   parameter int MAX_KEEP = nnk_pkg::MAX_KEEP_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nnk_pkg::cmd_type      cmd,
   output nnk_pkg::cell_type     head,
   output logic                  head_more,
   output logic [MAX_KEEP-1:0]   occ
);
   import nnk_pkg::*;

   localparam cell_type LEFT_EDGE  =
      '{occ: 1'b1, greater: 1'b1, distance: '0, target: '0};
   localparam cell_type RIGHT_EDGE =
      '{occ: 1'b0, greater: 1'b0, distance: '0, target: '0};

   cell_type cells [MAX_KEEP];

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      cell_type lft;
      cell_type rgt;

      if (i == 0) begin : g_first
         assign lft = LEFT_EDGE;
      end else begin : g_mid_l
         assign lft = cells[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_last
         assign rgt = RIGHT_EDGE;
      end else begin : g_mid_r
         assign rgt = cells[i+1];
      end

      nnk_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (lft),
         .right (rgt),
         .own   (cells[i])
      );

      assign occ[i] = cells[i].occ;
   end

   assign head = cells[0];

   if (MAX_KEEP > 1) begin : g_more
      assign head_more = cells[1].occ;
   end else begin : g_single
      assign head_more = 1'b0;
   end

endmodule

FILE: design/nearest_neighbour_top_k_select.sv
// Top level of the nearest-neighbour top-k selector: control, CSR and edge output register.
// Depends on nnk_pkg, nnk_ifs (nnk_req_if, nnk_rsp_if) and nnk_chain.
//
//   port   | dir | handshake    | word
//   -------+-----+--------------+----------------------------------------------------
//   req    | in  | valid/ready  | source_index, neighbour_index, distance, group_end
//   rsp    | out | valid/ready  | edge_source, edge_target, edge_distance, edge_last
//   csr    | in  | write enable | keep_count (5 bits), no read-back
//
// A candidate word is taken every cycle while in fill; the chain cells register its insert.
// A word with group_end closes req while the chain drains from its head, one edge
// word a cycle, held back by rsp stalls. The edge output register lets the next
// group start filling while the final edge word still waits on rsp. Synchronous
// active-high reset empties the chain (occupancy flags only) and loads keep_count
// with 12.
module nearest_neighbour_top_k_select #(
   parameter int MAX_KEEP = nnk_pkg::MAX_KEEP_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [nnk_pkg::KEEP_COUNT_W-1:0]   csr_write_data,
   nnk_req_if.sink                            req,
   nnk_rsp_if.source                          rsp
);
   import nnk_pkg::*;

   localparam int IdxW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type              state_ff, state_in;
   logic [KEEP_COUNT_W-1:0] keep_count_ff;
   logic [INDEX_W-1:0]     group_source_ff, group_source_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]     edge_source_ff, edge_source_in;
   logic [INDEX_W-1:0]     edge_target_ff, edge_target_in;
   logic [DIST_W-1:0]      edge_distance_ff, edge_distance_in;
   logic                   edge_last_ff, edge_last_in;

   cmd_type                cmd;
   cell_type               head;
   logic                   head_more;
   logic [MAX_KEEP-1:0]    occ;

   logic                   req_accept;
   logic                   full;
   logic                   pop;
   logic [31:0]            keep_wide;
   logic [IdxW-1:0]        limit_idx;

   // Clamp keep_count to 1..MAX_KEEP; the chain is full once slot limit-1 is taken
   assign keep_wide = 32'(keep_count_ff);

   always_comb begin
      priority if (keep_wide == 32'd0) begin
         limit_idx = '0;
      end else if (keep_wide > 32'(MAX_KEEP)) begin
         limit_idx = IdxW'(MAX_KEEP - 1);
      end else begin
         limit_idx = IdxW'(keep_wide - 32'd1);
      end
   end

   assign full = occ[limit_idx];

   assign req.ready  = (state_ff == ST_FILL);
   assign req_accept = req.valid && req.ready;

   // Advance the head into the output register whenever that register is free
   assign pop = (state_ff == ST_DRAIN) && head.occ && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      cmd.op       = OP_HOLD;
      cmd.distance = req.distance;
      cmd.target   = req.neighbour_index;
      if (req_accept && (req.neighbour_index != req.source_index)) begin
         // drop self candidates; once full, only a strictly smaller one replaces the head
         if (!full) begin
            cmd.op = OP_INSERT;
         end else if (head.greater) begin
            cmd.op = OP_REPLACE;
         end
      end else if (pop) begin
         cmd.op = OP_SHIFT;
      end
   end

   nnk_chain #(
      .MAX_KEEP (MAX_KEEP)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .head      (head),
      .head_more (head_more),
      .occ       (occ)
   );

   always_comb begin
      state_in         = state_ff;
      group_source_in  = group_source_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      edge_source_in   = edge_source_ff;
      edge_target_in   = edge_target_ff;
      edge_distance_in = edge_distance_ff;
      edge_last_in     = edge_last_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_accept) begin
               group_source_in = req.source_index;
               if (req.group_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!head.occ) begin
               // empty group: nothing to emit
               state_in = ST_FILL;
            end else if (pop) begin
               rsp_valid_in     = 1'b1;
               edge_source_in   = group_source_ff;
               edge_target_in   = head.target;
               edge_distance_in = head.distance;
               edge_last_in     = !head_more;
               if (!head_more) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_FILL;
         rsp_valid_ff     <= 1'b0;
         group_source_ff  <= '0;
         keep_count_ff    <= KEEP_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         group_source_ff  <= group_source_in;
         if (csr_write_enable) begin
            keep_count_ff <= csr_write_data;
         end
      end
      // edge payload needs no reset: rsp_valid_ff qualifies it
      edge_source_ff   <= edge_source_in;
      edge_target_ff   <= edge_target_in;
      edge_distance_ff <= edge_distance_in;
      edge_last_ff     <= edge_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.edge_source   = edge_source_ff;
   assign rsp.edge_target   = edge_target_ff;
   assign rsp.edge_distance = edge_distance_ff;
   assign rsp.edge_last     = edge_last_ff;

`ifndef SYNTHESIS
   // Occupied slots always form a prefix of the chain
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      ((occ & (occ + MAX_KEEP'(1))) == '0))
      else $error("chain occupancy is not contiguous from the head");

   // An insert grows the chain by exactly one edge
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INSERT) |=> ($countones(occ) == $past($countones(occ)) + 1))
      else $error("insert did not add exactly one edge");

   // A replace leaves the fill level unchanged
   a_replace_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_REPLACE) |=> $stable(occ))
      else $error("replace changed the fill level");

   // The last edge of a drain leaves the chain empty
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_more) |=> (occ == '0))
      else $error("chain not empty after the last edge word");
`endif

endmodule
